// ----- hw/rtl/asfcld_pkg.sv -----
// Shared types, constants and GUID tables of the ASF container length detector.
`timescale 1ns / 1ps

package asfcld_pkg;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_CHILD_WAIT,
        PH_CHILD,
        PH_BODY_WAIT,
        PH_BODY,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic        is_asf;
        logic [63:0] file_length;
    } t_verdict;

    localparam logic [63:0] HDR_LEN        = 64'd30;
    localparam logic [63:0] HEAD_LEN       = 64'd24;
    localparam logic [63:0] MIN_CHILD_HDR  = 64'd54;

    localparam logic [4:0]  POS_GUID_END   = 5'd15;
    localparam logic [4:0]  POS_SIZE_LO    = 5'd16;
    localparam logic [4:0]  POS_HEAD_END   = 5'd23;
    localparam logic [4:0]  POS_COUNT_LO   = 5'd24;
    localparam logic [4:0]  POS_COUNT_HI   = 5'd27;
    localparam logic [4:0]  POS_HDR_END    = 5'd29;

    localparam logic [6:0]  PROPS_D_FOUND  = 7'd23;
    localparam logic [6:0]  PROPS_SIZE_LO  = 7'd40;
    localparam logic [6:0]  PROPS_SIZE_HI  = 7'd47;
    localparam logic [6:0]  PROPS_FLAGS_AT = 7'd88;
    localparam logic [6:0]  PROPS_D_MAX    = 7'd127;

    localparam logic [7:0]  ASF_BROADCAST_FLAG = 8'h01;

    // byte 0 of each GUID sits in bits [7:0]
    localparam logic [127:0] GUID_HEADER = 128'h6CCE6200AA00D9A611CF668E75B22630;
    localparam logic [127:0] GUID_PROPS  = 128'h6553200CC000E48E11CFA9478CABDCA1;
    localparam logic [127:0] GUID_DATA   = 128'h6CCE6200AA00D9A611CF668E75B22636;
    localparam logic [127:0] GUID_IDX_A  = 128'hCB4903C9A000F48911CFE5B133000890;
    localparam logic [127:0] GUID_IDX_B  = 128'hBE4903C9A000349011D135DAD6E229D3;
    localparam logic [127:0] GUID_IDX_C  = 128'h8CD47A2F1D2A0F844C6412ADFEB103F8;
    localparam logic [127:0] GUID_IDX_D  = 128'h0C8F22B6F7ED3D9548030C4A3CB73FD0;

    function automatic logic is_body_guid(input logic [127:0] guid);
        is_body_guid = (guid == GUID_DATA)  || (guid == GUID_IDX_A) ||
                       (guid == GUID_IDX_B) || (guid == GUID_IDX_C) ||
                       (guid == GUID_IDX_D);
    endfunction

endpackage

// ----- hw/rtl/asfcld_parser.sv -----
// Per-byte header and object walk of the ASF container length detector.
`timescale 1ns / 1ps

module asfcld_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output asfcld_pkg::t_verdict o_verdict
);

    asfcld_pkg::t_phase r_phase, n_phase;
    logic         r_rejected, n_rejected;
    logic [63:0]  r_offset, n_offset;
    logic [63:0]  r_next_obj, n_next_obj;
    logic [4:0]   r_head_pos, n_head_pos;
    logic         r_props_seen, n_props_seen;
    logic         r_bcast, n_bcast;

    logic [127:0] r_guid, n_guid;
    logic [55:0]  r_size, n_size;
    logic [63:0]  r_hsize, n_hsize;
    logic [31:0]  r_left, n_left;
    logic [63:0]  r_room, n_room;
    logic [63:0]  r_body_end, n_body_end;
    logic [63:0]  r_pending, n_pending;
    logic [63:0]  r_pfs, n_pfs;
    logic [6:0]   r_props_d, n_props_d;

    logic [64:0]  offset_inc;
    logic         is_hdr, enter_child, enter_body, in_child, in_body, head_active;
    logic [4:0]   head_pos, pos;
    logic [63:0]  size_full, hsize_full, child_next;
    logic         head_done, hdr_guid_bad, hdr_size_bad, hdr_end;
    logic         size_small, size_over, room_low, last_child;
    logic [64:0]  room_diff, body_sum;
    logic [31:0]  left_dec;
    logic         child_ok, body_ok, props_hit;
    logic [6:0]   props_d;

    logic         tail_phase, hdr_covered, use_props, props_short, pend_hit, ok;
    logic [63:0]  length;

    assign offset_inc  = {1'b0, r_offset} + 65'd1;
    assign is_hdr      = (r_phase == asfcld_pkg::PH_HDR);
    assign enter_child = (r_phase == asfcld_pkg::PH_CHILD_WAIT) && (r_offset == r_next_obj);
    assign enter_body  = (r_phase == asfcld_pkg::PH_BODY_WAIT) && (r_offset == r_pending);
    assign in_child    = (r_phase == asfcld_pkg::PH_CHILD) || enter_child;
    assign in_body     = (r_phase == asfcld_pkg::PH_BODY) || enter_body;
    assign head_active = is_hdr || in_child || in_body;
    assign head_pos    = (enter_child || enter_body) ? 5'd0 : r_head_pos;
    assign pos         = is_hdr ? r_offset[4:0] : head_pos;

    assign size_full   = {i_data_byte, r_size};
    assign hsize_full  = {i_data_byte, r_hsize[55:0]};
    assign head_done   = (in_child || in_body) && (head_pos == asfcld_pkg::POS_HEAD_END);

    assign hdr_guid_bad = is_hdr && (pos == asfcld_pkg::POS_GUID_END) &&
                          (n_guid != asfcld_pkg::GUID_HEADER);
    assign hdr_size_bad = is_hdr && (pos == asfcld_pkg::POS_HEAD_END) &&
                          (hsize_full < asfcld_pkg::HDR_LEN);
    assign hdr_end      = is_hdr && (pos == asfcld_pkg::POS_HDR_END);

    assign size_small = (size_full < asfcld_pkg::HEAD_LEN);
    assign room_diff  = {1'b0, r_room} - {1'b0, size_full};
    assign size_over  = room_diff[64];
    assign room_low   = (room_diff[63:0] < asfcld_pkg::HEAD_LEN);
    assign left_dec   = r_left - 32'd1;
    assign last_child = (left_dec == 32'd0);
    assign child_next = r_next_obj + size_full;
    assign child_ok   = !size_small && !size_over;
    assign props_hit  = in_child && head_done && (r_guid == asfcld_pkg::GUID_PROPS);

    assign body_sum = {1'b0, r_body_end} + {1'b0, size_full};
    assign body_ok  = asfcld_pkg::is_body_guid(r_guid) && !size_small && !body_sum[64];

    assign props_d = props_hit ? asfcld_pkg::PROPS_D_FOUND : r_props_d;

    always_comb begin
        n_phase    = r_phase;
        n_rejected = r_rejected;
        if (!r_rejected) begin
            unique case (r_phase)
                asfcld_pkg::PH_HDR: begin
                    if (hdr_guid_bad || hdr_size_bad) begin
                        n_rejected = 1'b1;
                    end else if (hdr_end) begin
                        if (r_left == 32'd0) begin
                            n_phase = asfcld_pkg::PH_BODY_WAIT;
                        end else if (r_hsize < asfcld_pkg::MIN_CHILD_HDR) begin
                            n_rejected = 1'b1;
                        end else begin
                            n_phase = asfcld_pkg::PH_CHILD_WAIT;
                        end
                    end
                end
                asfcld_pkg::PH_CHILD_WAIT: begin
                    if (enter_child) begin
                        n_phase = asfcld_pkg::PH_CHILD;
                    end
                end
                asfcld_pkg::PH_CHILD: begin
                    if (head_done) begin
                        if (!child_ok) begin
                            n_rejected = 1'b1;
                        end else if (last_child) begin
                            n_phase = asfcld_pkg::PH_BODY_WAIT;
                        end else if (room_low) begin
                            n_rejected = 1'b1;
                        end else begin
                            n_phase = asfcld_pkg::PH_CHILD_WAIT;
                        end
                    end
                end
                asfcld_pkg::PH_BODY_WAIT: begin
                    if (enter_body) begin
                        n_phase = asfcld_pkg::PH_BODY;
                    end
                end
                asfcld_pkg::PH_BODY: begin
                    if (head_done) begin
                        n_phase = body_ok ? asfcld_pkg::PH_BODY_WAIT : asfcld_pkg::PH_DONE;
                    end
                end
                asfcld_pkg::PH_DONE: begin
                    n_phase = asfcld_pkg::PH_DONE;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_comb begin
        n_offset     = offset_inc[63:0];
        n_next_obj   = r_next_obj;
        n_head_pos   = r_head_pos;
        n_props_seen = r_props_seen;
        n_bcast      = r_bcast;
        n_guid       = r_guid;
        n_size       = r_size;
        n_hsize      = r_hsize;
        n_left       = r_left;
        n_room       = r_room;
        n_body_end   = r_body_end;
        n_pending    = r_pending;
        n_pfs        = r_pfs;
        n_props_d    = r_props_d;
        if (!r_rejected) begin
            if (head_active && (pos < asfcld_pkg::POS_SIZE_LO)) begin
                n_guid[{pos[3:0], 3'b000} +: 8] = i_data_byte;
            end
            if (is_hdr) begin
                if ((pos >= asfcld_pkg::POS_SIZE_LO) && (pos <= asfcld_pkg::POS_HEAD_END)) begin
                    n_hsize[{pos[2:0], 3'b000} +: 8] = i_data_byte;
                end
                if ((pos >= asfcld_pkg::POS_COUNT_LO) && (pos <= asfcld_pkg::POS_COUNT_HI)) begin
                    n_left[{pos[1:0], 3'b000} +: 8] = i_data_byte;
                end
                if (hdr_end) begin
                    n_room     = r_hsize - asfcld_pkg::HDR_LEN;
                    n_body_end = asfcld_pkg::HDR_LEN;
                    n_pending  = asfcld_pkg::HDR_LEN;
                end
            end
            if (in_child || in_body) begin
                n_head_pos = head_pos + 5'd1;
                if ((pos >= asfcld_pkg::POS_SIZE_LO) && (pos < asfcld_pkg::POS_HEAD_END)) begin
                    n_size[{pos[2:0], 3'b000} +: 8] = i_data_byte;
                end
            end
            if (enter_body) begin
                n_body_end = r_pending;
            end
            if (in_child && head_done && child_ok) begin
                n_next_obj = child_next;
                n_room     = room_diff[63:0];
                n_left     = left_dec;
                if (last_child) begin
                    n_body_end = child_next;
                    n_pending  = child_next;
                end
            end
            if (in_body && head_done && body_ok) begin
                n_pending = body_sum[63:0];
            end
            if (props_hit) begin
                n_props_seen = 1'b1;
                n_pfs        = '0;
                n_bcast      = 1'b0;
            end
            if (n_props_seen) begin
                if ((props_d >= asfcld_pkg::PROPS_SIZE_LO) &&
                    (props_d <= asfcld_pkg::PROPS_SIZE_HI)) begin
                    n_pfs[{props_d[2:0], 3'b000} +: 8] = i_data_byte;
                end
                if (props_d == asfcld_pkg::PROPS_FLAGS_AT) begin
                    n_bcast = |(i_data_byte & asfcld_pkg::ASF_BROADCAST_FLAG);
                end
            end
            n_props_d = (props_d == asfcld_pkg::PROPS_D_MAX) ? props_d : props_d + 7'd1;
        end
    end

    assign tail_phase  = (n_phase == asfcld_pkg::PH_BODY_WAIT) ||
                         (n_phase == asfcld_pkg::PH_BODY) ||
                         (n_phase == asfcld_pkg::PH_DONE);
    assign hdr_covered = (offset_inc >= {1'b0, r_hsize});
    assign use_props   = n_props_seen && !n_bcast;
    assign props_short = (n_pfs < r_hsize);
    assign pend_hit    = (n_phase == asfcld_pkg::PH_BODY_WAIT) &&
                         ({1'b0, n_pending} == offset_inc);
    assign ok          = !n_rejected && tail_phase && hdr_covered &&
                         !(use_props && props_short);
    assign length      = use_props ? n_pfs : (pend_hit ? n_pending : n_body_end);

    assign o_verdict.is_asf      = ok;
    assign o_verdict.file_length = ok ? length : 64'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_phase      <= asfcld_pkg::PH_HDR;
            r_rejected   <= 1'b0;
            r_offset     <= '0;
            r_next_obj   <= asfcld_pkg::HDR_LEN;
            r_head_pos   <= '0;
            r_props_seen <= 1'b0;
            r_bcast      <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_rejected   <= n_rejected;
            r_offset     <= n_offset;
            r_next_obj   <= n_next_obj;
            r_head_pos   <= n_head_pos;
            r_props_seen <= n_props_seen;
            r_bcast      <= n_bcast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_guid     <= n_guid;
            r_size     <= n_size;
            r_hsize    <= n_hsize;
            r_left     <= n_left;
            r_room     <= n_room;
            r_body_end <= n_body_end;
            r_pending  <= n_pending;
            r_pfs      <= n_pfs;
            r_props_d  <= n_props_d;
        end
    end

endmodule

// ----- hw/rtl/asf_container_length_detector.sv -----
// Top level of the ASF container length detector: input and result registers around the parser.
`timescale 1ns / 1ps

// Bytes of a candidate file enter one per cycle from offset zero; the byte flagged
// i_last_byte closes the stream and yields one transaction on the result side with
// o_is_asf and o_file_length (zero when not ASF), and the next byte starts a new stream.
// Every byte passes an input register and is then folded into the parser state; the
// verdict of a last byte is captured in the result register when that byte is folded in.
// Sustained rate is one byte per cycle, set by the per-byte state update in the parser;
// input is held back only while a last byte waits for a result register that still
// holds an untaken verdict.
module asf_container_length_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_asf,
    output logic [63:0] o_file_length
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    logic        r_out_is_asf;
    logic [63:0] r_out_length;

    logic                 proc_fire;
    logic                 in_fire;
    asfcld_pkg::t_verdict verdict;

    assign proc_fire = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || proc_fire;
    assign in_fire   = i_valid && o_ready;

    asfcld_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (proc_fire),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_verdict   (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && r_in_last) begin
            r_out_is_asf <= verdict.is_asf;
            r_out_length <= verdict.file_length;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_is_asf      = r_out_is_asf;
    assign o_file_length = r_out_length;

    a_reject_zero_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_is_asf) |-> (r_out_length == 64'd0))
        else $error("rejected stream carries a nonzero length");

    a_min_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_is_asf) |-> (r_out_length >= asfcld_pkg::HDR_LEN))
        else $error("accepted stream shorter than an ASF header");

    a_result_from_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(proc_fire && r_in_last))
        else $error("result appeared without a last byte");

endmodule

// ----- tb/tb_asf_container_length_detector.sv -----
// Self-checking testbench for the ASF container length detector: byte streams in, verdicts scored.
`timescale 1ns / 1ps

module tb_asf_container_length_detector;

    import asfcld_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_xfer;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_data_byte   = 8'h00;
    logic        i_last_byte   = 1'b0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_is_asf;
    logic [63:0] o_file_length;

    t_byte_xfer  byte_feed[$];
    t_byte_xfer  feed_head;
    logic [7:0]  stream_buf[$];
    t_verdict    verdicts_due[$];
    t_verdict    scan_result;
    t_verdict    due_verdict;
    logic        scan_emits;
    logic        in_fire        = 1'b0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatches     = 0;
    int          cycle_count    = 0;

    t_phase       scan_phase;
    logic [63:0]  scan_pos;
    logic [127:0] scan_guid_win;
    logic [63:0]  scan_size_win;
    logic [63:0]  scan_hdr_size;
    logic [31:0]  scan_hdr_count;
    logic [31:0]  scan_objs_done;
    logic [63:0]  scan_next_obj;
    logic [63:0]  scan_props_at;
    logic         scan_props_seen;
    logic [63:0]  scan_props_fsize;
    logic         scan_bcast;
    logic [63:0]  scan_run_end;
    logic [63:0]  scan_run_pending;
    logic         scan_reject;

    asf_container_length_detector u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_is_asf      (o_is_asf),
        .o_file_length (o_file_length)
    );

    task automatic clear_scan();
        scan_phase       = PH_HDR;
        scan_pos         = '0;
        scan_guid_win    = '0;
        scan_size_win    = '0;
        scan_hdr_size    = '0;
        scan_hdr_count   = '0;
        scan_objs_done   = '0;
        scan_next_obj    = HDR_LEN;
        scan_props_at    = '0;
        scan_props_seen  = 1'b0;
        scan_props_fsize = '0;
        scan_bcast       = 1'b0;
        scan_run_end     = '0;
        scan_run_pending = '0;
        scan_reject      = 1'b0;
    endtask

    task automatic enter_next_object();
        if (scan_objs_done == scan_hdr_count) begin
            scan_run_end     = scan_next_obj;
            scan_run_pending = scan_next_obj;
            scan_phase       = PH_BODY_WAIT;
        end else if (scan_next_obj > scan_hdr_size - HEAD_LEN) begin
            scan_reject = 1'b1;
        end else begin
            scan_phase = PH_CHILD_WAIT;
        end
    endtask

    task automatic shift_in_head(input logic [63:0] pos, input logic [7:0] b);
        if (pos <= POS_GUID_END)
            scan_guid_win[pos[3:0]*8 +: 8] = b;
        else if (pos <= POS_HEAD_END)
            scan_size_win = scan_size_win | ({56'd0, b} << (8 * (pos - POS_SIZE_LO)));
        if (pos == POS_SIZE_LO)
            scan_size_win = {56'd0, b};
    endtask

    task automatic asf_scan_byte(input logic [7:0] b, input logic last,
                                 output logic emits, output t_verdict verdict);
        logic [63:0] pos;
        logic [63:0] d;
        logic        ok;
        logic [63:0] len;
        emits   = 1'b0;
        verdict = '0;
        if (!scan_reject) begin
            if (scan_phase == PH_HDR) begin
                pos = scan_pos;
                if (pos <= POS_GUID_END)
                    scan_guid_win[pos[3:0]*8 +: 8] = b;
                if (pos == POS_GUID_END && scan_guid_win != GUID_HEADER)
                    scan_reject = 1'b1;
                if (pos >= POS_SIZE_LO && pos <= POS_HEAD_END)
                    scan_hdr_size = scan_hdr_size |
                                    ({56'd0, b} << (8 * (pos - POS_SIZE_LO)));
                if (pos == POS_HEAD_END && scan_hdr_size < HDR_LEN)
                    scan_reject = 1'b1;
                if (pos >= POS_COUNT_LO && pos <= POS_COUNT_HI)
                    scan_hdr_count = scan_hdr_count |
                                     ({24'd0, b} << (8 * (pos - POS_COUNT_LO)));
                if (pos == POS_HDR_END && !scan_reject)
                    enter_next_object();
            end else begin
                if (scan_phase == PH_CHILD_WAIT && scan_pos == scan_next_obj)
                    scan_phase = PH_CHILD;
                if (scan_phase == PH_BODY_WAIT && scan_pos == scan_run_pending) begin
                    scan_run_end = scan_run_pending;
                    scan_phase   = PH_BODY;
                end
                if (scan_phase == PH_CHILD) begin
                    pos = scan_pos - scan_next_obj;
                    shift_in_head(pos, b);
                    if (pos == POS_HEAD_END) begin
                        if (scan_guid_win == GUID_PROPS) begin
                            scan_props_at    = scan_next_obj;
                            scan_props_seen  = 1'b1;
                            scan_props_fsize = '0;
                            scan_bcast       = 1'b0;
                        end
                        if (scan_size_win < HEAD_LEN ||
                            scan_size_win > scan_hdr_size - scan_next_obj) begin
                            scan_reject = 1'b1;
                        end else begin
                            scan_next_obj  = scan_next_obj + scan_size_win;
                            scan_objs_done = scan_objs_done + 32'd1;
                            enter_next_object();
                        end
                    end
                end else if (scan_phase == PH_BODY) begin
                    pos = scan_pos - scan_run_end;
                    shift_in_head(pos, b);
                    if (pos == POS_HEAD_END) begin
                        if (!(scan_guid_win == GUID_DATA  || scan_guid_win == GUID_IDX_A ||
                              scan_guid_win == GUID_IDX_B || scan_guid_win == GUID_IDX_C ||
                              scan_guid_win == GUID_IDX_D) ||
                            scan_size_win < HEAD_LEN || scan_size_win > ~scan_run_end) begin
                            scan_phase = PH_DONE;
                        end else begin
                            scan_run_pending = scan_run_end + scan_size_win;
                            scan_phase       = PH_BODY_WAIT;
                        end
                    end
                end
            end
            if (scan_props_seen && scan_pos >= scan_props_at) begin
                d = scan_pos - scan_props_at;
                if (d >= PROPS_SIZE_LO && d <= PROPS_SIZE_HI)
                    scan_props_fsize = scan_props_fsize |
                                       ({56'd0, b} << (8 * (d - PROPS_SIZE_LO)));
                if (d == PROPS_FLAGS_AT)
                    scan_bcast = (b & ASF_BROADCAST_FLAG) != 8'h00;
            end
        end
        if (!last) begin
            scan_pos = scan_pos + 64'd1;
        end else begin
            ok = !scan_reject && scan_phase != PH_HDR && scan_phase != PH_CHILD &&
                 scan_phase != PH_CHILD_WAIT && scan_pos >= scan_hdr_size - 64'd1;
            len = '0;
            if (ok) begin
                if (scan_props_seen && !scan_bcast) begin
                    len = scan_props_fsize;
                    if (len < scan_hdr_size)
                        ok = 1'b0;
                end else if (scan_phase == PH_BODY_WAIT &&
                             scan_run_pending - 64'd1 <= scan_pos) begin
                    len = scan_run_pending;
                end else begin
                    len = scan_run_end;
                end
            end
            verdict.is_asf      = ok;
            verdict.file_length = ok ? len : 64'd0;
            emits = 1'b1;
            clear_scan();
        end
    endtask

    function automatic logic [127:0] maybe_damage(input logic [127:0] g, input int pct);
        int bitpos;
        bitpos = $urandom_range(127, 0);
        if ($urandom_range(99, 0) < pct)
            g[bitpos] = ~g[bitpos];
        return g;
    endfunction

    task automatic put_le(input logic [63:0] value, input int nbytes);
        int k;
        for (k = 0; k < nbytes; k++)
            stream_buf.push_back(value[8*k +: 8]);
    endtask

    task automatic put_guid(input logic [127:0] g);
        int k;
        for (k = 0; k < 16; k++)
            stream_buf.push_back(g[8*k +: 8]);
    endtask

    task automatic put_fill(input int nbytes);
        logic [31:0] r;
        int          k;
        for (k = 0; k < nbytes; k++) begin
            r = $urandom;
            stream_buf.push_back(r[7:0]);
        end
    endtask

    task automatic put_header(input logic [127:0] g, input logic [63:0] size_field,
                              input logic [63:0] count_field);
        put_guid(g);
        put_le(size_field, 8);
        put_le(count_field, 4);
        put_fill(2);
    endtask

    task automatic put_object(input logic [127:0] g, input logic [63:0] size_field,
                              input int obj_len);
        put_guid(g);
        put_le(size_field, 8);
        put_fill(obj_len - 24);
    endtask

    task automatic put_props(input logic [63:0] size_field, input int obj_len,
                             input logic [63:0] fsize, input logic flag);
        logic [7:0] fb;
        int         k;
        put_guid(GUID_PROPS);
        put_le(size_field, 8);
        for (k = 24; k < obj_len; k++) begin
            fb = $urandom;
            if (k >= PROPS_SIZE_LO && k <= PROPS_SIZE_HI)
                fb = fsize[8*(k - PROPS_SIZE_LO) +: 8];
            else if (k == PROPS_FLAGS_AT)
                fb[0] = flag;
            stream_buf.push_back(fb);
        end
    endtask

    task automatic ship_stream();
        t_byte_xfer xfer;
        int         k;
        if (stream_buf.size() == 0)
            put_fill(1);
        for (k = 0; k < stream_buf.size(); k++) begin
            xfer.data = stream_buf[k];
            xfer.last = (k == stream_buf.size() - 1);
            byte_feed.push_back(xfer);
        end
        stream_buf.delete();
    endtask

    task automatic build_noise();
        case ($urandom_range(2, 0))
            0: put_fill($urandom_range(40, 1));
            1: begin
                put_guid(GUID_HEADER);
                put_fill($urandom_range(30, 0));
            end
            default: begin
                put_header(GUID_HEADER, $urandom_range(80, 30), $urandom_range(3, 0));
                put_fill($urandom_range(60, 0));
            end
        endcase
    endtask

    task automatic build_random_asf();
        int           n_child;
        int           n_body;
        int           k;
        int           hsize;
        int           pick;
        int           obj_len;
        int           cut;
        int           child_len [4];
        bit           child_props [4];
        logic [63:0]  size_field;
        logic [63:0]  count_field;
        logic [63:0]  fsize;
        logic [127:0] g;
        logic [7:0]   spare_byte;
        n_child = $urandom_range(3, 0);
        hsize   = HDR_LEN;
        for (k = 0; k < n_child; k++) begin
            child_props[k] = $urandom_range(1, 0);
            if (child_props[k])
                child_len[k] = ($urandom_range(9, 0) < 3) ? 104 : $urandom_range(100, 24);
            else
                child_len[k] = $urandom_range(40, 24);
            hsize += child_len[k];
        end
        size_field = hsize;
        pick = $urandom_range(99, 0);
        if (pick < 4)
            size_field = $urandom_range(29, 0);
        else if (pick < 8)
            size_field = hsize - $urandom_range(20, 1);
        else if (pick < 12)
            size_field = hsize + $urandom_range(20, 1);
        count_field = n_child;
        pick = $urandom_range(99, 0);
        if (pick < 5)
            count_field = n_child + 1;
        else if (pick < 8)
            count_field = $urandom;
        put_header(maybe_damage(GUID_HEADER, 4), size_field, count_field);
        for (k = 0; k < n_child; k++) begin
            size_field = child_len[k];
            if ($urandom_range(99, 0) < 5)
                size_field = $urandom_range(23, 0);
            if (child_props[k]) begin
                pick = $urandom_range(99, 0);
                if (pick < 30)
                    fsize = $urandom_range(hsize - 1, 0);
                else if (pick < 70)
                    fsize = $urandom_range(hsize + 4000, hsize);
                else
                    fsize = {$urandom, $urandom};
                put_props(size_field, child_len[k], fsize, $urandom_range(1, 0));
            end else begin
                put_object({$urandom, $urandom, $urandom, $urandom}, size_field, child_len[k]);
            end
        end
        n_body = $urandom_range(3, 0);
        for (k = 0; k < n_body; k++) begin
            case ($urandom_range(4, 0))
                0:       g = GUID_DATA;
                1:       g = GUID_IDX_A;
                2:       g = GUID_IDX_B;
                3:       g = GUID_IDX_C;
                default: g = GUID_IDX_D;
            endcase
            if ($urandom_range(99, 0) < 8)
                g = {$urandom, $urandom, $urandom, $urandom};
            else
                g = maybe_damage(g, 3);
            obj_len    = $urandom_range(48, 24);
            size_field = obj_len;
            pick = $urandom_range(99, 0);
            if (pick < 4) begin
                size_field = $urandom_range(23, 0);
            end else if (pick < 8) begin
                size_field = 64'hFFFF_FFFF_FFFF_FF00 | $urandom_range(255, 0);
                obj_len    = 24;
            end else if (pick < 14) begin
                size_field = obj_len + $urandom_range(200, 1);
            end
            put_object(g, size_field, obj_len);
        end
        if ($urandom_range(99, 0) < 30)
            put_fill($urandom_range(20, 1));
        if ($urandom_range(99, 0) < 15) begin
            cut = $urandom_range(stream_buf.size(), 1);
            while (stream_buf.size() > cut)
                spare_byte = stream_buf.pop_back();
        end
    endtask

    task automatic wait_all_verdicts();
        @(posedge i_clk);
        while (byte_feed.size() != 0 || i_valid || verdicts_due.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            if (!i_valid || in_fire) begin
                if (byte_feed.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    feed_head = byte_feed.pop_front();
                    i_valid     <= 1'b1;
                    i_data_byte <= feed_head.data;
                    i_last_byte <= feed_head.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            asf_scan_byte(i_data_byte, i_last_byte, scan_emits, scan_result);
            if (scan_emits)
                verdicts_due.push_back(scan_result);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: expected no verdict, got is_asf %0b length %0d",
                         $time, o_is_asf, o_file_length);
                mismatches++;
            end else begin
                due_verdict = verdicts_due.pop_front();
                if (o_is_asf !== due_verdict.is_asf) begin
                    $display("%0t: is_asf expected %0b actual %0b",
                             $time, due_verdict.is_asf, o_is_asf);
                    mismatches++;
                end
                if (o_file_length !== due_verdict.file_length) begin
                    $display("%0t: file_length expected %0d actual %0d",
                             $time, due_verdict.file_length, o_file_length);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int phase;
        int streams;
        clear_scan();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        put_le(64'h00, 1);
        ship_stream();
        put_le(64'hFF, 1);
        ship_stream();
        put_header(GUID_HEADER, HDR_LEN, 0);
        spare_drop: begin
            logic [7:0] tail_byte;
            tail_byte = stream_buf.pop_back();
        end
        ship_stream();
        put_header(GUID_HEADER, HDR_LEN, 0);
        ship_stream();
        put_header(GUID_HEADER ^ 128'h1, HDR_LEN, 0);
        put_fill(10);
        ship_stream();
        put_header(GUID_HEADER, HDR_LEN - 64'd1, 0);
        put_fill(10);
        ship_stream();
        put_header(GUID_HEADER, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF);
        put_fill(4);
        ship_stream();
        put_header(GUID_HEADER, HDR_LEN, 64'hFFFF_FFFF);
        put_fill(30);
        ship_stream();
        put_header(GUID_HEADER, 134, 1);
        put_props(104, 104, 5000, 1'b0);
        ship_stream();
        put_header(GUID_HEADER, 134, 1);
        put_props(104, 104, 5000, 1'b1);
        put_object(GUID_DATA, 50, 50);
        put_object(GUID_IDX_D, 24, 24);
        ship_stream();
        put_header(GUID_HEADER, 134, 1);
        put_props(104, 104, 133, 1'b0);
        ship_stream();
        put_header(GUID_HEADER, 134, 2);
        put_props(60, 60, 4000, 1'b0);
        put_props(44, 44, 0, 1'b0);
        ship_stream();
        put_header(GUID_HEADER, 60, 1);
        put_object({$urandom, $urandom, $urandom, $urandom}, 23, 30);
        ship_stream();
        put_header(GUID_HEADER, 60, 1);
        put_object({$urandom, $urandom, $urandom, $urandom}, 31, 30);
        ship_stream();
        put_header(GUID_HEADER, HDR_LEN, 0);
        put_object(GUID_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 24);
        ship_stream();
        put_header(GUID_HEADER, HDR_LEN, 0);
        put_object(GUID_IDX_A, 40, 40);
        put_object({$urandom, $urandom, $urandom, $urandom}, 40, 40);
        ship_stream();
        put_header(GUID_HEADER, HDR_LEN, 0);
        put_object(GUID_IDX_B, 24, 24);
        put_object(GUID_IDX_C, 23, 24);
        ship_stream();
        put_header(GUID_HEADER, HDR_LEN, 0);
        put_object(GUID_DATA, 100, 40);
        ship_stream();
        put_header(GUID_HEADER, HDR_LEN, 0);
        put_object(GUID_DATA, 40, 40);
        put_fill(10);
        ship_stream();
        wait_all_verdicts();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                end
                default: begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            for (streams = 0; streams < 15; streams++) begin
                if ($urandom_range(3, 0) == 0)
                    build_noise();
                else
                    build_random_asf();
                ship_stream();
            end
            wait_all_verdicts();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/asfcld_pkg.sv
hw/rtl/asfcld_parser.sv
hw/rtl/asf_container_length_detector.sv
tb/tb_asf_container_length_detector.sv
